// ===== rtl/raster_home_jog_motion_sequencer_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RASTER_HOME_JOG_MOTION_SEQUENCER_TOP_DEFINES_SVH
`define RASTER_HOME_JOG_MOTION_SEQUENCER_TOP_DEFINES_SVH

// clocked property, off while reset is asserted (active low)
`define RHJMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property with a guard expression, off while reset is asserted (active low)
`define RHJMS_ASSERT_WHEN(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

// ===== rtl/rhjms_pkg.sv =====
// Package: types, codes and reset values of the raster/home/jog motion sequencer.
`default_nettype none
package rhjms_pkg;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_START_RASTER = 3'd1,
        OP_START_HOME   = 3'd2,
        OP_START_JOG    = 3'd3,
        OP_STOP         = 3'd4,
        OP_STOP_JOG     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RASTER = 2'd1,
        MODE_HOME   = 2'd2,
        MODE_JOG    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_X_FWD       = 2'd0,
        PH_Y_AFTER_FWD = 2'd1,
        PH_X_BWD       = 2'd2,
        PH_Y_AFTER_BWD = 2'd3
    } t_phase;

    typedef logic signed [10:0] t_drive;

    localparam logic [1:0] CFG_CUT_FEED   = 2'd0;
    localparam logic [1:0] CFG_HOME_FEED  = 2'd1;
    localparam logic [1:0] CFG_STEP_COUNT = 2'd2;

    localparam logic [9:0]  CUT_FEED_RST   = 10'd512;
    localparam logic [9:0]  HOME_FEED_RST  = 10'd1023;
    localparam logic [15:0] STEP_COUNT_RST = 16'd100;

endpackage
`default_nettype wire

// ===== rtl/raster_home_jog_motion_sequencer_top.sv =====
// Two-axis raster/home/jog motion sequencer, single-pass top level.
// One result word per input word, one word per clock sustained while the output
// is not stalled. An accepted word sits in the input register until the output
// can advance; then the mode/phase/counter state and the result register update
// together from it. The block keeps accepting while a result waits on a stalled
// output; only a stalled output with a full input register raises o_in_stall.
// Configuration writes are always ready and registered directly; index 3 is ignored.
`default_nettype none
module raster_home_jog_motion_sequencer_top
    import rhjms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_op,
    input  wire logic               i_x_start_hit,
    input  wire logic               i_x_end_hit,
    input  wire logic               i_y_start_hit,
    input  wire logic               i_y_end_hit,
    input  wire logic [7:0]         i_encoder_pulses,
    input  wire logic               i_joy_valid,
    input  wire logic signed [10:0] i_joy_x,
    input  wire logic signed [10:0] i_joy_y,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [10:0]      o_x_drive,
    output logic signed [10:0]      o_y_drive,
    output logic [1:0]              o_mode_now,
    output logic                    o_finished,
    output logic                    o_refused
);

    // joystick -1024 clamps to -1023
    function automatic t_drive sat_joy(input t_drive v);
        return (v == 11'sh400) ? 11'sh401 : v;
    endfunction

    // configuration
    logic [9:0]  r_cut_feed;
    logic [9:0]  r_home_feed;
    logic [15:0] r_step_count;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic        r_in_xs, r_in_xe, r_in_ys, r_in_ye;
    logic [7:0]  r_in_pulses;
    logic        r_in_joy_valid;
    t_drive      r_in_joy_x, r_in_joy_y;

    // sequencer state
    t_mode       r_mode,     n_mode;
    t_phase      r_phase,    n_phase;
    logic [15:0] r_step_cnt, n_step_cnt;
    t_drive      r_x_hold,   n_x_hold;
    t_drive      r_y_hold,   n_y_hold;
    logic        n_finished, n_refused;

    // result register
    logic        r_out_valid;
    t_drive      r_out_x, r_out_y;
    logic [1:0]  r_out_mode;
    logic        r_out_finished, r_out_refused;

    logic        adv_out;
    logic        do_item;
    logic [16:0] cnt_sum;
    logic [15:0] cnt_sat;
    t_drive      jx, jy, cut_pos, cut_neg, trv_neg;

    assign adv_out     = !r_out_valid || !i_out_stall;
    assign do_item     = r_in_valid && adv_out;
    assign o_in_stall  = r_in_valid && !adv_out;
    assign o_cfg_ready = 1'b1;

    assign cnt_sum = {1'b0, r_step_cnt} + {9'd0, r_in_pulses};
    assign cnt_sat = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
    assign jx      = sat_joy(r_in_joy_x);
    assign jy      = sat_joy(r_in_joy_y);
    assign cut_pos = t_drive'({1'b0, r_cut_feed});
    assign cut_neg = -cut_pos;
    assign trv_neg = -t_drive'({1'b0, r_home_feed});

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_step_cnt = r_step_cnt;
        n_x_hold   = r_x_hold;
        n_y_hold   = r_y_hold;
        n_finished = 1'b0;
        n_refused  = 1'b0;
        unique case (t_op'(r_in_op))
            OP_TICK: begin
                unique case (r_mode)
                    MODE_RASTER: begin
                        unique case (r_phase)
                            PH_X_FWD: begin
                                if (r_in_xe) begin
                                    n_x_hold   = '0;
                                    n_phase    = PH_Y_AFTER_FWD;
                                    n_step_cnt = '0;
                                    n_y_hold   = cut_pos;
                                end
                            end
                            PH_X_BWD: begin
                                if (r_in_xs) begin
                                    n_x_hold   = '0;
                                    n_phase    = PH_Y_AFTER_BWD;
                                    n_step_cnt = '0;
                                    n_y_hold   = cut_pos;
                                end
                            end
                            PH_Y_AFTER_FWD, PH_Y_AFTER_BWD: begin
                                // Y end limit wins over the step count
                                if (r_in_ye) begin
                                    n_x_hold   = '0;
                                    n_y_hold   = '0;
                                    n_mode     = MODE_IDLE;
                                    n_phase    = PH_X_FWD;
                                    n_finished = 1'b1;
                                end else begin
                                    n_step_cnt = cnt_sat;
                                    if (cnt_sat >= r_step_count) begin
                                        n_y_hold = '0;
                                        if (r_phase == PH_Y_AFTER_FWD) begin
                                            n_phase  = PH_X_BWD;
                                            n_x_hold = cut_neg;
                                        end else begin
                                            n_phase  = PH_X_FWD;
                                            n_x_hold = cut_pos;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                    MODE_HOME: begin
                        if (r_in_xs) n_x_hold = '0;
                        if (r_in_ys) n_y_hold = '0;
                        if (r_in_xs && r_in_ys) begin
                            n_mode     = MODE_IDLE;
                            n_finished = 1'b1;
                        end
                    end
                    MODE_JOG: begin
                        if (r_in_joy_valid) begin
                            if ((!jx[10] && jx != '0 && !r_in_xe) || (jx[10] && !r_in_xs))
                                n_x_hold = jx;
                            else
                                n_x_hold = '0;
                            if ((!jy[10] && jy != '0 && !r_in_ye) || (jy[10] && !r_in_ys))
                                n_y_hold = jy;
                            else
                                n_y_hold = '0;
                        end
                    end
                    MODE_IDLE: ;
                endcase
            end
            OP_START_RASTER: begin
                if (r_mode != MODE_IDLE) begin
                    n_refused = 1'b1;
                end else begin
                    n_mode     = MODE_RASTER;
                    n_phase    = PH_X_FWD;
                    n_step_cnt = '0;
                    n_x_hold   = cut_pos;
                    n_y_hold   = '0;
                end
            end
            OP_START_HOME: begin
                if (r_mode != MODE_IDLE) begin
                    n_refused = 1'b1;
                end else begin
                    n_mode   = MODE_HOME;
                    n_x_hold = trv_neg;
                    n_y_hold = trv_neg;
                end
            end
            OP_START_JOG: begin
                if (r_mode != MODE_IDLE) begin
                    n_refused = 1'b1;
                end else begin
                    n_mode   = MODE_JOG;
                    n_x_hold = '0;
                    n_y_hold = '0;
                end
            end
            OP_STOP: begin
                n_x_hold = '0;
                n_y_hold = '0;
                if (r_mode == MODE_RASTER || r_mode == MODE_HOME) begin
                    n_mode  = MODE_IDLE;
                    n_phase = PH_X_FWD;
                end
            end
            OP_STOP_JOG: begin
                n_x_hold = '0;
                n_y_hold = '0;
                if (r_mode == MODE_JOG) n_mode = MODE_IDLE;
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_feed   <= CUT_FEED_RST;
            r_home_feed  <= HOME_FEED_RST;
            r_step_count <= STEP_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CUT_FEED:   r_cut_feed   <= i_cfg_data[9:0];
                CFG_HOME_FEED:  r_home_feed  <= i_cfg_data[9:0];
                CFG_STEP_COUNT: r_step_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_op        <= i_op;
            r_in_xs        <= i_x_start_hit;
            r_in_xe        <= i_x_end_hit;
            r_in_ys        <= i_y_start_hit;
            r_in_ye        <= i_y_end_hit;
            r_in_pulses    <= i_encoder_pulses;
            r_in_joy_valid <= i_joy_valid;
            r_in_joy_x     <= i_joy_x;
            r_in_joy_y     <= i_joy_y;
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_phase    <= PH_X_FWD;
            r_step_cnt <= '0;
            r_x_hold   <= '0;
            r_y_hold   <= '0;
        end else if (do_item) begin
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_step_cnt <= n_step_cnt;
            r_x_hold   <= n_x_hold;
            r_y_hold   <= n_y_hold;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_item) begin
            r_out_x        <= n_x_hold;
            r_out_y        <= n_y_hold;
            r_out_mode     <= n_mode;
            r_out_finished <= n_finished;
            r_out_refused  <= n_refused;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_drive   = r_out_x;
    assign o_y_drive   = r_out_y;
    assign o_mode_now  = r_out_mode;
    assign o_finished  = r_out_finished;
    assign o_refused   = r_out_refused;

endmodule
`default_nettype wire

// ===== rtl/rhjms_checker.sv =====
// Port-level checker for the motion sequencer top level, with its bind.
`default_nettype none
`include "raster_home_jog_motion_sequencer_top_defines.svh"
module rhjms_checker
    import rhjms_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [10:0] o_x_drive,
    input wire logic signed [10:0] o_y_drive,
    input wire logic [1:0]         o_mode_now,
    input wire logic               o_finished,
    input wire logic               o_refused
);

    logic [25:0] out_word;
    logic        out_wait;
    logic        out_fin;
    logic        out_ref;
    logic        fin_ok;
    logic        ref_ok;
    logic        drv_ok;

    assign out_word = {o_x_drive, o_y_drive, o_mode_now, o_finished, o_refused};
    assign out_wait = o_out_valid && i_out_stall;
    assign out_fin  = o_out_valid && o_finished;
    assign out_ref  = o_out_valid && o_refused;
    assign fin_ok   = (o_mode_now == MODE_IDLE) && (o_x_drive == 11'sd0)
                      && (o_y_drive == 11'sd0);
    assign ref_ok   = (o_mode_now != MODE_IDLE) && !o_finished;
    // drives never reach the unused negative code
    assign drv_ok   = (o_x_drive != 11'sh400) && (o_y_drive != 11'sh400);

    // a stalled result word holds
    property p_out_hold;
        out_wait |=> o_out_valid && $stable(out_word);
    endproperty

    `RHJMS_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled result word changed")

    // a completed run leaves the axes stopped and the block idle
    `RHJMS_ASSERT_WHEN(a_fin_idle, i_clk, i_rst_n, out_fin, fin_ok, "finish not idle")

    // a refused start only happens with a mode still running
    `RHJMS_ASSERT_WHEN(a_ref_busy, i_clk, i_rst_n, out_ref, ref_ok, "refusal while idle")

    `RHJMS_ASSERT_WHEN(a_drive_rng, i_clk, i_rst_n, o_out_valid, drv_ok, "drive out of range")

endmodule

bind raster_home_jog_motion_sequencer_top rhjms_checker u_rhjms_checker (.*);
`default_nettype wire

// ===== tb/rhjms_tb_pkg.sv =====
`timescale 1ns / 100ps
// Word types and the drive/mode scoreboard for the motion sequencer testbench.
package rhjms_tb_pkg;
    import rhjms_pkg::*;

    typedef struct {
        logic [2:0]         op;
        logic               x_start_hit;
        logic               x_end_hit;
        logic               y_start_hit;
        logic               y_end_hit;
        logic [7:0]         encoder_pulses;
        logic               joy_valid;
        logic signed [10:0] joy_x;
        logic signed [10:0] joy_y;
    } t_cmd_word;

    typedef struct {
        t_drive     x_drive;
        t_drive     y_drive;
        logic [1:0] mode_now;
        logic       finished;
        logic       refused;
    } t_drive_word;

    class motion_scoreboard;
        logic [9:0]  cut_feed;
        logic [9:0]  home_feed;
        logic [15:0] step_target;
        t_mode       mode;
        t_phase      phase;
        logic [15:0] step_seen;
        t_drive      x_hold;
        t_drive      y_hold;
        t_drive_word expected_drives[$];
        int          errors;

        function new();
            cut_feed    = CUT_FEED_RST;
            home_feed   = HOME_FEED_RST;
            step_target = STEP_COUNT_RST;
            mode        = MODE_IDLE;
            phase       = PH_X_FWD;
            step_seen   = '0;
            x_hold      = '0;
            y_hold      = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_CUT_FEED:   cut_feed    = data[9:0];
                CFG_HOME_FEED:  home_feed   = data[9:0];
                CFG_STEP_COUNT: step_target = data;
                default: ;
            endcase
        endfunction

        function t_drive speed(logic [9:0] mag);
            return t_drive'({1'b0, mag});
        endfunction

        function void enter_y_step(t_phase next_phase);
            phase     = next_phase;
            step_seen = '0;
            y_hold    = speed(cut_feed);
        endfunction

        // joystick axis after saturation of -1024 and limit gating
        function t_drive gate(logic signed [10:0] joy, logic lo_hit, logic hi_hit);
            t_drive v;
            v = (joy == 11'h400) ? -11'sd1023 : joy;
            if ((v > 0 && !hi_hit) || (v < 0 && !lo_hit))
                return v;
            return '0;
        endfunction

        function logic raster_tick(t_cmd_word w);
            logic [16:0] sum;
            raster_tick = 1'b0;
            case (phase)
                PH_X_FWD: if (w.x_end_hit) begin
                    x_hold = '0;
                    enter_y_step(PH_Y_AFTER_FWD);
                end
                PH_X_BWD: if (w.x_start_hit) begin
                    x_hold = '0;
                    enter_y_step(PH_Y_AFTER_BWD);
                end
                default: begin
                    // Y end limit wins over the step count
                    if (w.y_end_hit) begin
                        x_hold      = '0;
                        y_hold      = '0;
                        mode        = MODE_IDLE;
                        phase       = PH_X_FWD;
                        raster_tick = 1'b1;
                    end else begin
                        sum       = {1'b0, step_seen} + {9'd0, w.encoder_pulses};
                        step_seen = sum[16] ? 16'hFFFF : sum[15:0];
                        if (step_seen >= step_target) begin
                            y_hold = '0;
                            if (phase == PH_Y_AFTER_FWD) begin
                                phase  = PH_X_BWD;
                                x_hold = -speed(cut_feed);
                            end else begin
                                phase  = PH_X_FWD;
                                x_hold = speed(cut_feed);
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void note_command(t_cmd_word w);
            t_drive_word r;
            r.finished = 1'b0;
            r.refused  = 1'b0;
            case (w.op)
                OP_TICK: begin
                    case (mode)
                        MODE_RASTER: r.finished = raster_tick(w);
                        MODE_HOME: begin
                            if (w.x_start_hit) x_hold = '0;
                            if (w.y_start_hit) y_hold = '0;
                            if (w.x_start_hit && w.y_start_hit) begin
                                mode       = MODE_IDLE;
                                r.finished = 1'b1;
                            end
                        end
                        MODE_JOG: if (w.joy_valid) begin
                            x_hold = gate(w.joy_x, w.x_start_hit, w.x_end_hit);
                            y_hold = gate(w.joy_y, w.y_start_hit, w.y_end_hit);
                        end
                        default: ;
                    endcase
                end
                OP_START_RASTER, OP_START_HOME, OP_START_JOG: begin
                    if (mode != MODE_IDLE) begin
                        r.refused = 1'b1;
                    end else if (w.op == OP_START_RASTER) begin
                        mode      = MODE_RASTER;
                        phase     = PH_X_FWD;
                        step_seen = '0;
                        x_hold    = speed(cut_feed);
                        y_hold    = '0;
                    end else if (w.op == OP_START_HOME) begin
                        mode   = MODE_HOME;
                        x_hold = -speed(home_feed);
                        y_hold = -speed(home_feed);
                    end else begin
                        mode   = MODE_JOG;
                        x_hold = '0;
                        y_hold = '0;
                    end
                end
                OP_STOP: begin
                    x_hold = '0;
                    y_hold = '0;
                    if (mode == MODE_RASTER || mode == MODE_HOME) begin
                        mode  = MODE_IDLE;
                        phase = PH_X_FWD;
                    end
                end
                OP_STOP_JOG: begin
                    x_hold = '0;
                    y_hold = '0;
                    if (mode == MODE_JOG)
                        mode = MODE_IDLE;
                end
                default: ;
            endcase
            r.x_drive  = x_hold;
            r.y_drive  = y_hold;
            r.mode_now = mode;
            expected_drives.push_back(r);
        endfunction

        function void check_drives(t_drive_word got);
            t_drive_word want;
            if (expected_drives.size() == 0) begin
                $error("unexpected result word: x_drive %0d, y_drive %0d, mode_now %0d",
                       got.x_drive, got.y_drive, got.mode_now);
                errors++;
                return;
            end
            want = expected_drives.pop_front();
            if (got.x_drive !== want.x_drive) begin
                $error("x_drive mismatch: expected %0d, actual %0d", want.x_drive, got.x_drive);
                errors++;
            end
            if (got.y_drive !== want.y_drive) begin
                $error("y_drive mismatch: expected %0d, actual %0d", want.y_drive, got.y_drive);
                errors++;
            end
            if (got.mode_now !== want.mode_now) begin
                $error("mode_now mismatch: expected %0d, actual %0d",
                       want.mode_now, got.mode_now);
                errors++;
            end
            if (got.finished !== want.finished) begin
                $error("finished mismatch: expected %0d, actual %0d",
                       want.finished, got.finished);
                errors++;
            end
            if (got.refused !== want.refused) begin
                $error("refused mismatch: expected %0d, actual %0d", want.refused, got.refused);
                errors++;
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

endpackage

// ===== tb/raster_home_jog_motion_sequencer_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the motion sequencer: directed and random command words, scoreboard checks.
module raster_home_jog_motion_sequencer_top_tb;
    import rhjms_pkg::*;
    import rhjms_tb_pkg::*;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         RAND_WORDS_PER_PHASE = 185;
    localparam int         NUM_PHASES = 6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_op = '0;
    logic               i_x_start_hit = 1'b0;
    logic               i_x_end_hit = 1'b0;
    logic               i_y_start_hit = 1'b0;
    logic               i_y_end_hit = 1'b0;
    logic [7:0]         i_encoder_pulses = '0;
    logic               i_joy_valid = 1'b0;
    logic signed [10:0] i_joy_x = '0;
    logic signed [10:0] i_joy_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [10:0] o_x_drive;
    logic signed [10:0] o_y_drive;
    logic [1:0]         o_mode_now;
    logic               o_finished;
    logic               o_refused;

    motion_scoreboard sb;
    t_drive_word      seen_word;
    bit               gaps_on = 1'b0;
    int               stall_left = 0;
    int               words_sent = 0;

    raster_home_jog_motion_sequencer_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_x_start_hit    (i_x_start_hit),
        .i_x_end_hit      (i_x_end_hit),
        .i_y_start_hit    (i_y_start_hit),
        .i_y_end_hit      (i_y_end_hit),
        .i_encoder_pulses (i_encoder_pulses),
        .i_joy_valid      (i_joy_valid),
        .i_joy_x          (i_joy_x),
        .i_joy_y          (i_joy_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_x_drive        (o_x_drive),
        .o_y_drive        (o_y_drive),
        .o_mode_now       (o_mode_now),
        .o_finished       (o_finished),
        .o_refused        (o_refused)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 16);
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_word.x_drive  = o_x_drive;
            seen_word.y_drive  = o_y_drive;
            seen_word.mode_now = o_mode_now;
            seen_word.finished = o_finished;
            seen_word.refused  = o_refused;
            sb.check_drives(seen_word);
        end
    end

    function automatic logic signed [10:0] rand_joy();
        case ($urandom_range(0, 5))
            0: return 11'h400;
            1: return -11'sd1023;
            2: return 11'sd1023;
            3: return '0;
            default: return 11'($urandom);
        endcase
    endfunction

    function automatic t_cmd_word cmd(input logic [2:0] op, input logic xs, input logic xe,
                                      input logic ys, input logic ye, input logic [7:0] pulses,
                                      input logic jv, input logic signed [10:0] jx,
                                      input logic signed [10:0] jy);
        t_cmd_word w;
        w.op             = op;
        w.x_start_hit    = xs;
        w.x_end_hit      = xe;
        w.y_start_hit    = ys;
        w.y_end_hit      = ye;
        w.encoder_pulses = pulses;
        w.joy_valid      = jv;
        w.joy_x          = jx;
        w.joy_y          = jy;
        return w;
    endfunction

    function automatic t_cmd_word rand_cmd(input logic [2:0] op);
        return cmd(op, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   8'($urandom), 1'($urandom), rand_joy(), rand_joy());
    endfunction

    function automatic logic one_in(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    task automatic send_cmd(input t_cmd_word w);
        if (gaps_on && one_in(5)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= w.op;
        i_x_start_hit    <= w.x_start_hit;
        i_x_end_hit      <= w.x_end_hit;
        i_y_start_hit    <= w.y_start_hit;
        i_y_end_hit      <= w.y_end_hit;
        i_encoder_pulses <= w.encoder_pulses;
        i_joy_valid      <= w.joy_valid;
        i_joy_x          <= w.joy_x;
        i_joy_y          <= w.joy_y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_command(w);
        words_sent++;
    endtask

    // sender holds off until every expected word is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_settings(input logic [9:0] cut, input logic [9:0] trav,
                                 input logic [15:0] steps);
        wait_drained();
        write_cfg(CFG_CUT_FEED, {6'($urandom), cut});
        write_cfg(CFG_HOME_FEED, {6'($urandom), trav});
        write_cfg(CFG_STEP_COUNT, steps);
        write_cfg(CFG_UNUSED, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // steady: X limits always hit, no Y end hit and big pulse counts, so Y steps run to the count
    task automatic raster_run(input int ticks, input bit steady);
        t_cmd_word w;
        int        k;
        if (steady) begin
            send_cmd(rand_cmd(OP_STOP));
            send_cmd(rand_cmd(OP_STOP_JOG));
        end
        send_cmd(rand_cmd(OP_START_RASTER));
        for (k = 0; k < ticks; k++) begin
            w = rand_cmd(OP_TICK);
            if (steady) begin
                w.x_start_hit    = 1'b1;
                w.x_end_hit      = 1'b1;
                w.y_end_hit      = 1'b0;
                w.encoder_pulses = 8'($urandom_range(250, 255));
            end else begin
                w.x_start_hit = one_in(4);
                w.x_end_hit   = one_in(4);
                w.y_end_hit   = one_in(16);
                if (one_in(4))
                    w.encoder_pulses = 8'($urandom_range(0, 16));
                if (one_in(40))
                    w.op = 3'($urandom_range(1, 7));
            end
            send_cmd(w);
        end
    endtask

    task automatic home_run(input int ticks);
        t_cmd_word w;
        int        k;
        send_cmd(rand_cmd(OP_START_HOME));
        for (k = 0; k < ticks; k++) begin
            w = rand_cmd(OP_TICK);
            w.x_start_hit = one_in(4);
            w.y_start_hit = one_in(4);
            if (one_in(30))
                w.op = 3'($urandom_range(1, 7));
            send_cmd(w);
        end
    endtask

    task automatic jog_run(input int ticks);
        t_cmd_word w;
        int        k;
        send_cmd(rand_cmd(OP_START_JOG));
        for (k = 0; k < ticks; k++) begin
            w = rand_cmd(OP_TICK);
            w.joy_valid   = !one_in(4);
            w.x_start_hit = one_in(4);
            w.x_end_hit   = one_in(4);
            w.y_start_hit = one_in(4);
            w.y_end_hit   = one_in(4);
            if (one_in(20))
                w.op = OP_STOP;
            else if (one_in(30))
                w.op = 3'($urandom_range(1, 7));
            send_cmd(w);
        end
        send_cmd(rand_cmd(OP_STOP_JOG));
    endtask

    task automatic noise_burst(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_cmd(rand_cmd(3'($urandom_range(0, 7))));
    endtask

    initial begin
        int p;
        int r;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;

        // directed words on reset settings (cutting 512, travel 1023, step 100)
        send_cmd(cmd(OP_UNUSED_6, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 11'sd1023, 11'h400));
        send_cmd(cmd(OP_UNUSED_7, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_STOP_JOG, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_START_RASTER, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 11'sd1023,
                     11'sd1023));
        send_cmd(cmd(OP_START_HOME, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 8'hFF, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 8'd10, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_START_HOME, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_START_JOG, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 11'sd500, 11'sd500));
        send_cmd(cmd(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 11'h400, 11'sd1023));
        send_cmd(cmd(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b1, 11'sd1023, -11'sd1023));
        send_cmd(cmd(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd7, 11'sd7));
        send_cmd(cmd(OP_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, -11'sd1023, 11'sd500));
        send_cmd(cmd(OP_START_RASTER, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_STOP_JOG, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_START_RASTER, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_STOP_JOG, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));
        send_cmd(cmd(OP_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 11'sd0, 11'sd0));

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_settings(10'd1023, 10'd0, 16'd0);
                1: load_settings(10'd0, 10'd1023, 16'd1);
                2: load_settings(10'd1, 10'd1, 16'hFFFF);
                3: load_settings(10'($urandom), 10'($urandom), 16'($urandom_range(50, 600)));
                4: load_settings(10'($urandom), 10'($urandom), 16'($urandom_range(0, 2000)));
                default: load_settings(CUT_FEED_RST, HOME_FEED_RST, STEP_COUNT_RST);
            endcase
            // max step target: one full Y step, counter saturates on the way
            if (p == 2)
                raster_run(270, 1'b1);
            while (words_sent < 25 + (p + 1) * RAND_WORDS_PER_PHASE) begin
                gaps_on = (p != NUM_PHASES - 1) && !one_in(4);
                r = $urandom_range(0, 99);
                if (r < 40)
                    raster_run($urandom_range(4, 40), 1'b0);
                else if (r < 60)
                    home_run($urandom_range(2, 12));
                else if (r < 85)
                    jog_run($urandom_range(3, 20));
                else
                    noise_burst($urandom_range(1, 6));
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rhjms_pkg.sv
rtl/raster_home_jog_motion_sequencer_top.sv
rtl/rhjms_checker.sv
tb/rhjms_tb_pkg.sv
tb/raster_home_jog_motion_sequencer_top_tb.sv
